[sv/gnid_pkg.sv]
// Package for the grid neighbour ID generator: shared widths, register
// indexes, the queue entry type and the offset tables.
// No dependencies.
package gnid_pkg;

    localparam int ID_W          = 30;
    localparam int TYPE_W        = 5;
    localparam int SIZE_W        = 11;
    localparam int CFG_IDX_W     = 3;
    localparam int AXIS_BITS_DEF = 10;
    localparam int NUM_OFF       = 27;
    localparam int CENTRE        = 13;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X = 3'd0,
        REG_SIZE_Y = 3'd1,
        REG_SIZE_Z = 3'd2,
        REG_WRAP_X = 3'd3,
        REG_WRAP_Y = 3'd4,
        REG_WRAP_Z = 3'd5
    } t_reg;

    // One classified cell. Bit 0 of each axis mask is the -1 offset, bit 1 the
    // centre, bit 2 the +1 offset. zp and yp hold the candidate index already
    // scaled by the plane size and the row size.
    typedef struct packed {
        logic [2:0][ID_W-1:0] zp;
        logic [2:0][ID_W-1:0] yp;
        logic [2:0][ID_W-1:0] xs;
        logic [2:0]           mx;
        logic [2:0]           my;
        logic [2:0]           mz;
        logic                 oor;
    } t_cell;

    // Visiting order: position p = dx*9 + dy*3 + dz, each offset coded 0..2.
    localparam logic [1:0] OFF_DX [NUM_OFF] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] OFF_DY [NUM_OFF] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2,
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2,
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] OFF_DZ [NUM_OFF] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

    function automatic logic [TYPE_W-1:0] nb_type(input logic [4:0] p);
        return TYPE_W'(OFF_DZ[p]) * TYPE_W'(9) + TYPE_W'(OFF_DY[p]) * TYPE_W'(3)
             + TYPE_W'(OFF_DX[p]);
    endfunction

    function automatic logic [NUM_OFF-1:0] keep_mask(input t_cell c);
        logic [NUM_OFF-1:0] m;
        for (int p = 0; p < NUM_OFF; p++) begin
            m[p] = c.mx[OFF_DX[p]] & c.my[OFF_DY[p]] & c.mz[OFF_DZ[p]] & (p != CENTRE);
        end
        return m;
    endfunction

    function automatic logic [4:0] lowest_set(input logic [NUM_OFF-1:0] m);
        logic [4:0] r;
        logic       f;
        r = '0;
        f = 1'b0;
        for (int i = 0; i < NUM_OFF; i++) begin
            if (!f && m[i]) begin
                r = 5'(i);
                f = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

[sv/gnid_if.sv]
// Channel interfaces for the grid neighbour ID generator.
// Depends on gnid_pkg for the field widths.
interface gnid_cell_if;
    logic                      valid;
    logic                      ready;
    logic [gnid_pkg::ID_W-1:0] cell_id;
    modport source (output valid, output cell_id, input ready);
    modport sink (input valid, input cell_id, output ready);
endinterface

interface gnid_nbr_if;
    logic                        valid;
    logic                        ready;
    logic [gnid_pkg::ID_W-1:0]   neighbour_id;
    logic [gnid_pkg::TYPE_W-1:0] neighbour_type;
    logic                        neighbour_valid;
    logic                        last_of_cell;
    modport source (output valid, output neighbour_id, output neighbour_type,
                    output neighbour_valid, output last_of_cell, input ready);
    modport sink (input valid, input neighbour_id, input neighbour_type,
                  input neighbour_valid, input last_of_cell, output ready);
endinterface

interface gnid_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gnid_pkg::CFG_IDX_W-1:0] index;
    logic [gnid_pkg::SIZE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/gnid_front.sv]
// Front end: buffers one cell ID, splits it into x, y, z with a shared
// restoring divider, and builds the scaled neighbour candidates.
// Depends on gnid_pkg and gnid_if.
module gnid_front #(
    parameter int AXIS_BITS = gnid_pkg::AXIS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gnid_cell_if.sink             i_cell,
    input  logic [AXIS_BITS:0]    i_sx,
    input  logic [AXIS_BITS:0]    i_sy,
    input  logic [AXIS_BITS:0]    i_sz,
    input  logic [2:0]            i_wrap,
    input  logic                  i_full,
    output logic                  o_push,
    output gnid_pkg::t_cell       o_entry
);
    localparam int IW   = gnid_pkg::ID_W;
    localparam int SW   = AXIS_BITS + 1;
    localparam int PW   = 2 * SW;
    localparam int VW   = 3 * SW;
    localparam int Q    = AXIS_BITS;
    localparam int CW   = VW + IW;
    localparam int PRW  = Q + PW;
    localparam int CNTW = $clog2(Q + 1);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_DIVZ = 5'b00010,
        F_DIVY = 5'b00100,
        F_MUL  = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    t_fstate         r_state, n_state;
    logic            r_ib_full, n_ib_full;
    logic [IW-1:0]   r_ib_id;
    logic [PW-1:0]   r_plane;
    logic [VW-1:0]   r_vol;
    logic [IW-1:0]   r_rem, n_rem;
    logic [CW-1:0]   r_dsh, n_dsh;
    logic [Q-1:0]    r_q, n_q;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [Q-1:0]    r_x, n_x, r_y, n_y, r_z, n_z;
    logic            r_oor, n_oor;
    logic [1:0]      r_k, n_k;
    logic [2:0][IW-1:0] r_zp, n_zp, r_yp, n_yp;

    logic          ge;
    logic [IW-1:0] rem_step;
    logic [Q-1:0]  q_step;
    logic [Q-1:0]  cx [3];
    logic [Q-1:0]  cy [3];
    logic [Q-1:0]  cz [3];
    logic [2:0]    mx, my, mz;

    function automatic void axis_cand(input logic [Q-1:0] idx, input logic [SW-1:0] s,
                                      input logic w, output logic [Q-1:0] lo,
                                      output logic [Q-1:0] hi, output logic [2:0] m);
        logic at_hi;
        at_hi = (SW'(idx) + SW'(1)) >= s;
        lo    = (idx == '0) ? Q'(s - SW'(1)) : idx - Q'(1);
        hi    = at_hi ? '0 : idx + Q'(1);
        m     = {!at_hi || w, 1'b1, (idx != '0) || w};
    endfunction

    assign i_cell.ready = !r_ib_full;

    assign ge       = CW'(r_rem) >= r_dsh;
    assign rem_step = ge ? r_rem - IW'(r_dsh) : r_rem;
    assign q_step   = Q'({r_q, ge});

    always_comb begin
        axis_cand(r_x, i_sx, i_wrap[0], cx[0], cx[2], mx);
        axis_cand(r_y, i_sy, i_wrap[1], cy[0], cy[2], my);
        axis_cand(r_z, i_sz, i_wrap[2], cz[0], cz[2], mz);
        cx[1] = r_x;
        cy[1] = r_y;
        cz[1] = r_z;
    end

    always_comb begin
        n_state   = r_state;
        n_ib_full = r_ib_full;
        n_rem     = r_rem;
        n_dsh     = r_dsh;
        n_q       = r_q;
        n_cnt     = r_cnt;
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_oor     = r_oor;
        n_k       = r_k;
        n_zp      = r_zp;
        n_yp      = r_yp;
        o_push    = 1'b0;
        if (i_cell.valid && i_cell.ready) begin
            n_ib_full = 1'b1;
        end
        unique case (r_state)
            F_IDLE: begin
                if (r_ib_full) begin
                    n_ib_full = 1'b0;
                    n_rem     = r_ib_id;
                    n_dsh     = CW'(r_plane) << (Q - 1);
                    n_cnt     = '0;
                    n_state   = F_DIVZ;
                end
            end
            F_DIVZ: begin
                // The grid bound is checked in the cycle after setup, so that a size
                // written just before the cell has already reached r_vol.
                if (r_cnt == '0) begin
                    n_oor = CW'(r_rem) >= CW'(r_vol);
                end
                n_rem = rem_step;
                n_q   = q_step;
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(Q - 1)) begin
                    n_z     = q_step;
                    n_dsh   = CW'(i_sx) << (Q - 1);
                    n_cnt   = '0;
                    n_state = F_DIVY;
                end
            end
            F_DIVY: begin
                n_rem = rem_step;
                n_q   = q_step;
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(Q - 1)) begin
                    n_y     = q_step;
                    n_x     = Q'(rem_step);
                    n_k     = '0;
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_zp[r_k] = IW'(PRW'(cz[r_k]) * PRW'(r_plane));
                n_yp[r_k] = IW'(PRW'(cy[r_k]) * PRW'(i_sx));
                n_k       = r_k + 2'd1;
                if (r_k == 2'd2) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_entry.zp  = r_zp;
        o_entry.yp  = r_yp;
        o_entry.xs  = {IW'(cx[2]), IW'(cx[1]), IW'(cx[0])};
        o_entry.mx  = mx;
        o_entry.my  = my;
        o_entry.mz  = mz;
        o_entry.oor = r_oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_ib_full <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ib_full <= n_ib_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cell.valid && i_cell.ready) begin
            r_ib_id <= i_cell.cell_id;
        end
        r_plane <= PW'(i_sx) * PW'(i_sy);
        r_vol   <= VW'(r_plane) * VW'(i_sz);
        r_rem   <= n_rem;
        r_dsh   <= n_dsh;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_oor   <= n_oor;
        r_k     <= n_k;
        r_zp    <= n_zp;
        r_yp    <= n_yp;
    end

endmodule

[sv/gnid_queue.sv]
// Short queue of classified cells between the front and back ends.
// Depends on gnid_pkg.
module gnid_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gnid_pkg::t_cell i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output gnid_pkg::t_cell o_head
);
    localparam int DEPTH = gnid_pkg::QUEUE_DEPTH;
    localparam int PTRW  = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    gnid_pkg::t_cell r_mem [DEPTH];
    logic [PTRW-1:0] r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;

    assign o_full  = r_cnt == CNTW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTRW'(DEPTH - 1)) ? '0 : r_wp + PTRW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTRW'(DEPTH - 1)) ? '0 : r_rp + PTRW'(1);
            end
            r_cnt <= r_cnt + CNTW'(i_push) - CNTW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

[sv/gnid_back.sv]
// Back end: walks the kept neighbours of one cell, one per cycle unless the
// output stalls, into the output register. Depends on gnid_pkg and gnid_if.
module gnid_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  gnid_pkg::t_cell i_head,
    output logic            o_pop,
    gnid_nbr_if.source      o_nbr
);
    localparam int IW = gnid_pkg::ID_W;
    localparam int TW = gnid_pkg::TYPE_W;
    localparam int NO = gnid_pkg::NUM_OFF;

    logic            r_busy;
    gnid_pkg::t_cell r_e;
    logic [NO-1:0]   r_m;
    logic            r_ov;
    logic [IW-1:0]   r_nid;
    logic [TW-1:0]   r_ntype;
    logic            r_nvalid;
    logic            r_last;

    gnid_pkg::t_cell cur_e;
    logic [NO-1:0]   cur_m, new_m;
    logic [4:0]      p;
    logic            have, fire, any, last;
    logic [IW-1:0]   nid;

    assign cur_e = r_busy ? r_e : i_head;
    assign cur_m = r_busy ? r_m : (gnid_pkg::keep_mask(i_head) & {NO{!i_head.oor}});
    assign have  = r_busy || !i_empty;
    assign fire  = have && (!r_ov || o_nbr.ready);
    assign p     = gnid_pkg::lowest_set(cur_m);
    assign any   = |cur_m;
    assign new_m = cur_m & ~(NO'(1) << p);
    assign last  = !any || (new_m == '0);
    assign nid   = cur_e.zp[gnid_pkg::OFF_DZ[p]] + cur_e.yp[gnid_pkg::OFF_DY[p]]
                 + cur_e.xs[gnid_pkg::OFF_DX[p]];
    assign o_pop = fire && !r_busy;

    assign o_nbr.valid           = r_ov;
    assign o_nbr.neighbour_id    = r_nid;
    assign o_nbr.neighbour_type  = r_ntype;
    assign o_nbr.neighbour_valid = r_nvalid;
    assign o_nbr.last_of_cell    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else if (fire) begin
            r_busy <= !last;
            r_ov   <= 1'b1;
        end else if (o_nbr.ready) begin
            r_ov   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_e      <= cur_e;
            r_m      <= new_m;
            r_nid    <= any ? nid : '0;
            r_ntype  <= any ? gnid_pkg::nb_type(p) : '0;
            r_nvalid <= any;
            r_last   <= last;
        end
    end

endmodule

[sv/grid_neighbour_id_generator.sv]
// Top level of the grid neighbour ID generator: configuration registers, front end,
// queue and back end. Depends on gnid_pkg, gnid_if, gnid_front, gnid_queue, gnid_back.
//
// Usage: i_cell carries one linear cell ID per transaction. For each cell,
// o_nbr returns every kept neighbour of the 26 around it (x offset outermost,
// z innermost), each with its linear ID and offset code, and marks the final
// one with last_of_cell. A cell outside the grid, or one with no neighbour
// kept, yields a single result with neighbour_valid low.
// i_cfg writes the sizes and wrap bits and is always ready; it must be written by
// the user only while the block is idle, which the block itself does not enforce.
// Reset sets all sizes to 1 and clears the wrap bits. An accepted cell passes the
// input buffer, the front end states F_DIVZ, F_DIVY, F_MUL and F_PUSH, the queue
// and the output register; the divider runs AXIS_BITS steps for z and AXIS_BITS
// steps for y. A cell yields at most 26 results. A one-entry input buffer and a
// two-entry queue let the next cells be taken while results drain. When the
// receiver stalls, the output register holds its result, the back end waits,
// and the queue and input fill up.
module grid_neighbour_id_generator #(
    parameter int AXIS_BITS = gnid_pkg::AXIS_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gnid_cell_if.sink  i_cell,
    gnid_nbr_if.source o_nbr,
    gnid_cfg_if.sink   i_cfg
);
    localparam int SZW = gnid_pkg::SIZE_W;
    localparam int SW  = AXIS_BITS + 1;
    localparam int CLW = (SZW > SW) ? SZW : SW;

    logic [SZW-1:0]  r_size_x, r_size_y, r_size_z;
    logic [2:0]      r_wrap;
    logic [SW-1:0]   sx, sy, sz;
    logic            push, pop, full, empty;
    gnid_pkg::t_cell entry, head;

    function automatic logic [SW-1:0] clamp(input logic [SZW-1:0] v);
        logic [CLW-1:0] e;
        e = CLW'(v);
        if (e == '0) begin
            e = CLW'(1);
        end else if (e > (CLW'(1) << AXIS_BITS)) begin
            e = CLW'(1) << AXIS_BITS;
        end
        return SW'(e);
    endfunction

    assign i_cfg.ready = 1'b1;
    assign sx = clamp(r_size_x);
    assign sy = clamp(r_size_y);
    assign sz = clamp(r_size_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SZW'(1);
            r_size_y <= SZW'(1);
            r_size_z <= SZW'(1);
            r_wrap   <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                gnid_pkg::REG_SIZE_X: r_size_x  <= i_cfg.data;
                gnid_pkg::REG_SIZE_Y: r_size_y  <= i_cfg.data;
                gnid_pkg::REG_SIZE_Z: r_size_z  <= i_cfg.data;
                gnid_pkg::REG_WRAP_X: r_wrap[0] <= i_cfg.data[0];
                gnid_pkg::REG_WRAP_Y: r_wrap[1] <= i_cfg.data[0];
                gnid_pkg::REG_WRAP_Z: r_wrap[2] <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    gnid_front #(.AXIS_BITS(AXIS_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (i_cell),
        .i_sx    (sx),
        .i_sy    (sy),
        .i_sz    (sz),
        .i_wrap  (r_wrap),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    gnid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    gnid_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_nbr   (o_nbr)
    );

endmodule

[sv/gnid_checker.sv]
// Port-level checks for the grid neighbour ID generator, bound to the top level.
// Depends on gnid_pkg.
module gnid_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [gnid_pkg::ID_W-1:0]   i_nid,
    input logic [gnid_pkg::TYPE_W-1:0] i_ntype,
    input logic                        i_nvalid,
    input logic                        i_last
);
    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_nid)
        && $stable(i_ntype) && $stable(i_nvalid) && $stable(i_last))
        else $error("stalled result changed");

    // An empty result is always the only one of its cell and carries zeros.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_nvalid |-> i_last && i_nid == '0 && i_ntype == '0)
        else $error("empty result malformed");

    // The centre offset is never emitted and codes stay below 27.
    a_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_nvalid |-> i_ntype != 5'd13 && i_ntype <= 5'd26)
        else $error("bad neighbour type");

    // No result is shown right after reset.
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind grid_neighbour_id_generator gnid_checker u_gnid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_nbr.valid),
    .i_out_ready (o_nbr.ready),
    .i_nid       (o_nbr.neighbour_id),
    .i_ntype     (o_nbr.neighbour_type),
    .i_nvalid    (o_nbr.neighbour_valid),
    .i_last      (o_nbr.last_of_cell)
);

[test/gnid_tb_if.sv]
`timescale 1ns / 100ps
// Testbench copy point for the channel interfaces: nothing extra is needed here,
// the RTL interfaces in gnid_if are used directly. Depends on gnid_pkg.
package gnid_tb_pkg;
    typedef struct packed {
        logic [gnid_pkg::ID_W-1:0]   nid;
        logic [gnid_pkg::TYPE_W-1:0] ntype;
        logic                        nvalid;
        logic                        last;
    } t_nbr_exp;
endpackage

[test/grid_neighbour_id_generator_tb.sv]
`timescale 1ns / 100ps
// Testbench for grid_neighbour_id_generator: drives cell IDs under several grid
// settings, predicts the neighbour list of each cell and checks every result.
// Depends on gnid_pkg, gnid_if and gnid_tb_pkg.
module grid_neighbour_id_generator_tb;

    localparam int ID_W      = gnid_pkg::ID_W;
    localparam int TYPE_W    = gnid_pkg::TYPE_W;
    localparam int SIZE_W    = gnid_pkg::SIZE_W;
    localparam int LATENCY   = 2 * gnid_pkg::AXIS_BITS_DEF + 40;
    localparam int MAX_CYCLE = 2000000;

    logic i_clk;
    logic i_rst_n;
    gnid_cell_if cell_ch();
    gnid_nbr_if  nbr_ch();
    gnid_cfg_if  cfg_ch();

    grid_neighbour_id_generator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cell(cell_ch.sink), .o_nbr(nbr_ch.source), .i_cfg(cfg_ch.sink)
    );

    gnid_tb_pkg::t_nbr_exp pending_nbrs[$];
    int       errors;
    int       cycles;
    logic [SIZE_W-1:0] reg_size[3];
    logic              reg_wrap[3];
    bit  hold_off;
    bit  quiet_sink;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint eff_size(input logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    // One axis step: returns 0 when the neighbour falls off a closed axis.
    function automatic bit axis_move(input longint idx, input int d, input longint sz,
                                     input logic wrap, output longint res);
        res = idx;
        if (d < 0) begin
            if (idx == 0) begin
                if (!wrap) return 0;
                res = sz - 1;
            end else res = idx - 1;
        end else if (d > 0) begin
            if (idx + 1 >= sz) begin
                if (!wrap) return 0;
                res = 0;
            end else res = idx + 1;
        end
        return 1;
    endfunction

    task automatic predict_neighbours(input logic [ID_W-1:0] cid);
        longint sx, sy, sz, plane, x, y, z, nx, ny, nz;
        int n;
        gnid_tb_pkg::t_nbr_exp e;
        sx = eff_size(reg_size[0]);
        sy = eff_size(reg_size[1]);
        sz = eff_size(reg_size[2]);
        plane = sx * sy;
        n = 0;
        if (cid >= plane * sz) begin
            pending_nbrs.push_back('{0, 0, 1'b0, 1'b1});
            return;
        end
        z = cid / plane;
        y = (cid - z * plane) / sx;
        x = cid - z * plane - y * sx;
        for (int dx = -1; dx <= 1; dx++)
            for (int dy = -1; dy <= 1; dy++)
                for (int dz = -1; dz <= 1; dz++) begin
                    if (dx == 0 && dy == 0 && dz == 0) continue;
                    if (!axis_move(x, dx, sx, reg_wrap[0], nx)) continue;
                    if (!axis_move(y, dy, sy, reg_wrap[1], ny)) continue;
                    if (!axis_move(z, dz, sz, reg_wrap[2], nz)) continue;
                    e.nid    = ID_W'(nz * plane + ny * sx + nx);
                    e.ntype  = TYPE_W'((dz + 1) * 9 + (dy + 1) * 3 + (dx + 1));
                    e.nvalid = 1'b1;
                    e.last   = 1'b0;
                    pending_nbrs.push_back(e);
                    n++;
                end
        if (n == 0) pending_nbrs.push_back('{0, 0, 1'b0, 1'b1});
        else pending_nbrs[pending_nbrs.size() - 1].last = 1'b1;
    endtask

    // Result checker: ready toggles at the falling edge, sampling at the rising edge.
    initial begin
        int wait_cnt;
        gnid_tb_pkg::t_nbr_exp e;
        nbr_ch.ready = 1'b0;
        wait_cnt = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) nbr_ch.ready <= 1'b0;
            else if (quiet_sink) nbr_ch.ready <= 1'b1;
            else if (wait_cnt > 0) begin
                nbr_ch.ready <= 1'b0;
                wait_cnt--;
            end else begin
                nbr_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (nbr_ch.valid && nbr_ch.ready) begin
                if (!quiet_sink && !hold_off) wait_cnt = ($urandom_range(0, 3) == 0)
                    ? $urandom_range(0, 16) : 0;
                if (pending_nbrs.size() == 0) begin
                    $error("unexpected result id=%0d", nbr_ch.neighbour_id);
                    errors++;
                end else begin
                    e = pending_nbrs.pop_front();
                    if (nbr_ch.neighbour_id !== e.nid) begin
                        $error("neighbour_id: expected %0d, got %0d", e.nid,
                               nbr_ch.neighbour_id);
                        errors++;
                    end
                    if (nbr_ch.neighbour_type !== e.ntype) begin
                        $error("neighbour_type: expected %0d, got %0d", e.ntype,
                               nbr_ch.neighbour_type);
                        errors++;
                    end
                    if (nbr_ch.neighbour_valid !== e.nvalid) begin
                        $error("neighbour_valid: expected %0d, got %0d", e.nvalid,
                               nbr_ch.neighbour_valid);
                        errors++;
                    end
                    if (nbr_ch.last_of_cell !== e.last) begin
                        $error("last_of_cell: expected %0d, got %0d", e.last,
                               nbr_ch.last_of_cell);
                        errors++;
                    end
                end
            end
        end
    end

    // Called at a falling edge. Blocking drives let a back-to-back transaction
    // take over at the same falling edge where the previous one is released.
    task automatic send_cell(input logic [ID_W-1:0] cid, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 16)) : 0);
        repeat (gap) @(negedge i_clk);
        cell_ch.valid   = 1'b1;
        cell_ch.cell_id = cid;
        @(posedge i_clk);
        while (!cell_ch.ready) @(posedge i_clk);
        predict_neighbours(cid);
        @(negedge i_clk);
        cell_ch.valid   = 1'b0;
        cell_ch.cell_id = ID_W'($urandom);
    endtask

    task automatic drain;
        while (pending_nbrs.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input gnid_pkg::t_reg idx, input logic [SIZE_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            gnid_pkg::REG_SIZE_X: reg_size[0] = val;
            gnid_pkg::REG_SIZE_Y: reg_size[1] = val;
            gnid_pkg::REG_SIZE_Z: reg_size[2] = val;
            gnid_pkg::REG_WRAP_X: reg_wrap[0] = val[0];
            gnid_pkg::REG_WRAP_Y: reg_wrap[1] = val[0];
            gnid_pkg::REG_WRAP_Z: reg_wrap[2] = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_grid(input int sx, input int sy, input int sz,
                            input logic [SIZE_W-1:0] wx, input logic [SIZE_W-1:0] wy,
                            input logic [SIZE_W-1:0] wz);
        drain();
        write_reg(gnid_pkg::REG_SIZE_X, SIZE_W'(sx));
        write_reg(gnid_pkg::REG_SIZE_Y, SIZE_W'(sy));
        write_reg(gnid_pkg::REG_SIZE_Z, SIZE_W'(sz));
        write_reg(gnid_pkg::REG_WRAP_X, wx);
        write_reg(gnid_pkg::REG_WRAP_Y, wy);
        write_reg(gnid_pkg::REG_WRAP_Z, wz);
    endtask

    function automatic logic [ID_W-1:0] grid_cells;
        return ID_W'(eff_size(reg_size[0]) * eff_size(reg_size[1]) * eff_size(reg_size[2]));
    endfunction

    task automatic test_reset_grid;
        // After reset the grid is one cell with closed axes.
        send_cell(0, 0);
        send_cell(1, 0);
        send_cell({ID_W{1'b1}}, 0);
    endtask

    task automatic test_directed;
        set_grid(4, 3, 5, 0, 0, 0);
        send_cell(0, 0);
        send_cell(17, 0);
        send_cell(59, 0);
        send_cell(60, 0);
        set_grid(4, 3, 5, 1, 1, 1);
        send_cell(0, 0);
        send_cell(59, 0);
        send_cell(30, 0);
        // Periodic size-1 axes list the cell as its own neighbour; wrap uses bit 0 only.
        set_grid(1, 1, 1, 11'h7FF, 11'h3, 11'h5);
        send_cell(0, 0);
        set_grid(1, 1, 1, 11'h7FE, 0, 0);
        send_cell(0, 0);
        // Zero sizes act as 1, oversized ones as 1024.
        set_grid(0, 2047, 1025, 0, 1, 0);
        send_cell(0, 0);
        send_cell(1023, 0);
        send_cell(1024 * 1024 - 1, 0);
        send_cell(1024 * 1024 * 1024 - 1, 0);
        set_grid(1024, 1024, 1024, 1, 1, 1);
        send_cell(0, 0);
        send_cell({ID_W{1'b1}}, 0);
        send_cell(30'h2AAAAAAA, 0);
        send_cell(30'h15555555, 0);
        drain();
        write_reg(gnid_pkg::t_reg'(3'd6), 11'h7FF);
        write_reg(gnid_pkg::t_reg'(3'd7), 11'h0);
        send_cell(5, 0);
    endtask

    task automatic test_random(input int count);
        logic [ID_W-1:0] cid;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) cid = ID_W'($urandom);
            else cid = ID_W'($urandom_range(0, grid_cells() - 1));
            send_cell(cid, 0);
        end
    endtask

    task automatic test_backpressure;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_cell(ID_W'($urandom_range(0, grid_cells() - 1)), 1);
        join
        // Sender pauses until all results are in, then bursts against a fast sink.
        while (pending_nbrs.size() != 0) @(posedge i_clk);
        quiet_sink = 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < 6; i++)
            send_cell(ID_W'($urandom_range(0, grid_cells() - 1)), 1);
        drain();
        quiet_sink = 1'b0;
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        hold_off = 1'b0;
        quiet_sink = 1'b0;
        reg_size = '{1, 1, 1};
        reg_wrap = '{0, 0, 0};
        cell_ch.valid = 1'b0;
        cell_ch.cell_id = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_grid();
        test_directed();
        set_grid(7, 5, 3, 0, 1, 0);
        test_random(30);
        set_grid(3, 1, 6, 1, 0, 1);
        test_random(20);
        set_grid(2, 2, 2, 1, 1, 0);
        test_backpressure();
        set_grid($urandom_range(1, 1024), $urandom_range(1, 64), $urandom_range(1, 16),
                 SIZE_W'($urandom_range(0, 1)), SIZE_W'($urandom_range(0, 1)),
                 SIZE_W'($urandom_range(0, 1)));
        test_random(25);
        drain();

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[files.f]
sv/gnid_pkg.sv
sv/gnid_if.sv
sv/gnid_front.sv
sv/gnid_queue.sv
sv/gnid_back.sv
sv/grid_neighbour_id_generator.sv
sv/gnid_checker.sv
test/gnid_tb_if.sv
test/grid_neighbour_id_generator_tb.sv
